### sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and defaults of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // fixed field widths
  localparam int unsigned CNT_W  = 15;
  localparam int unsigned ADDR_W = 40;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // parameter defaults
  localparam int unsigned MAX_PAGES_DEF      = 16384;
  localparam int unsigned PAGE_SHIFT_DEF     = 12;
  localparam int unsigned RESERVED_PAGES_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF      = 32;

  // register index of page_count
  localparam logic REG_PAGE_COUNT = 1'b0;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE        = 2'd2;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_RESP
  } state_e;

endpackage

### sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator over a used-bit map held in one RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// command   in         start & !busy              operation_i, free_address_i
// result    out        done_o, one cycle, no stall status_o, page_address_o,
//                                                  free_count_o, used_count_o
// config    in         apb psel/penable/pwrite    page_count at address 0
//
// query (any code but alloc and free): the sequencer goes straight from
// S_IDLE to S_RESP; free: through S_FCHK to S_RESP (straight to S_RESP when
// the address is out of range); alloc: S_SCAN reads the map one word a cycle
// through the RAM read port up to the first word with a clear bit, then
// S_RESP, or straight to S_RESP with no free page. busy drops as the
// sequencer leaves S_RESP for S_IDLE. after reset and after every page_count
// write a clearing pass writes the map one word a cycle, with busy high.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES      = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT     = bpa_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned RESERVED_PAGES = bpa_pkg::RESERVED_PAGES_DEF,
  parameter int unsigned WORD_BITS      = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start,
  output logic                         busy,
  input  logic [bpa_pkg::OP_W-1:0]     operation_i,
  input  logic [bpa_pkg::ADDR_W-1:0]   free_address_i,
  // result
  output logic                         done_o,
  output logic [bpa_pkg::ST_W-1:0]     status_o,
  output logic [bpa_pkg::ADDR_W-1:0]   page_address_o,
  output logic [bpa_pkg::CNT_W-1:0]    free_count_o,
  output logic [bpa_pkg::CNT_W-1:0]    used_count_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]   paddr,
  input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
  output logic [bpa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  import bpa_pkg::*;

  localparam int unsigned DEPTH   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned BW      = $clog2(WORD_BITS);
  localparam int unsigned PIDX_W  = AW + BW;
  localparam int unsigned RST_RSV =
    (RESERVED_PAGES < MAX_PAGES) ? RESERVED_PAGES : MAX_PAGES;

  state_e state_q, state_d;

  logic [CNT_W-1:0]     page_count_q, page_count_d;
  logic [CNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]     used_cnt_q, used_cnt_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [OP_W-1:0]      op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [ST_W-1:0]      status_q, status_d;
  logic [ADDR_W-1:0]    pa_q, pa_d;

  logic                 cfg_wr;
  logic [CNT_W-1:0]     cfg_val;
  logic [CNT_W-1:0]     rsv_cap;
  logic                 accept;
  logic [ADDR_W-1:0]    in_idx;
  logic                 in_range;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [WORD_BITS-1:0] clr_word;
  logic                 word_full;
  logic [BW-1:0]        zero_pos;
  logic [BW-1:0]        free_bit;
  logic [WORD_BITS-1:0] free_mask;
  logic [WORD_BITS-1:0] alloc_mask;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);
  assign prdata = (paddr[2] == REG_PAGE_COUNT) ? APB_DW'(page_count_q) : '0;

  // clamp written page count
  always_comb begin
    cfg_val = pwdata[CNT_W-1:0];
    if (32'(pwdata[CNT_W-1:0]) > 32'(MAX_PAGES)) begin
      cfg_val = CNT_W'(MAX_PAGES);
    end
  end

  // reserved pages capped at the page count
  always_comb begin
    rsv_cap = page_count_q;
    if (32'(RESERVED_PAGES) < 32'(page_count_q)) begin
      rsv_cap = CNT_W'(RESERVED_PAGES);
    end
  end

  // command decode
  assign accept   = start && !busy;
  assign in_idx   = free_address_i >> PAGE_SHIFT;
  assign in_range = in_idx < ADDR_W'(page_count_q);

  // word image written by the clearing pass
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      clr_word[b] = ADDR_W'({ptr_q, BW'(b)}) < ADDR_W'(rsv_cap);
    end
  end

  // lowest clear bit of the word returned by the scan
  always_comb begin
    zero_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        zero_pos = BW'(b);
      end
    end
  end

  assign word_full  = &ram_rdata;
  assign alloc_mask = WORD_BITS'(1) << zero_pos;
  assign free_bit   = addr_q[PAGE_SHIFT +: BW];
  assign free_mask  = WORD_BITS'(1) << free_bit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (ptr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_ALLOC && free_cnt_q != '0) begin
            state_d = S_SCAN;
          end else if (operation_i == OP_FREE && in_range) begin
            state_d = S_FCHK;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!word_full) begin
          state_d = S_RESP;
        end
      end
      S_FCHK:  state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_wr) begin
      state_d = S_CLEAR;
    end
  end

  // datapath and memory controls
  always_comb begin
    page_count_d = page_count_q;
    free_cnt_d   = free_cnt_q;
    used_cnt_d   = used_cnt_q;
    ptr_d        = ptr_q;
    status_d     = status_q;
    pa_d         = pa_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = clr_word;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q + AW'(1);
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          pa_d     = '0;
          ram_re   = 1'b1;
          ptr_d    = '0;
          ram_raddr = '0;
          if (operation_i == OP_ALLOC) begin
            if (free_cnt_q == '0) begin
              status_d = ST_NO_FREE;
            end
          end else if (operation_i == OP_FREE) begin
            ptr_d     = in_idx[BW +: AW];
            ram_raddr = in_idx[BW +: AW];
            if (!in_range) begin
              status_d = ST_RANGE;
            end
          end
        end
      end
      S_SCAN: begin
        // lookahead read of the next word while this one is checked
        ram_re = word_full;
        if (word_full) begin
          ptr_d = ptr_q + AW'(1);
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata | alloc_mask;
          free_cnt_d = free_cnt_q - CNT_W'(1);
          used_cnt_d = used_cnt_q + CNT_W'(1);
          pa_d       = ADDR_W'({ptr_q, zero_pos}) << PAGE_SHIFT;
        end
      end
      S_FCHK: begin
        if (!(|(ram_rdata & free_mask))) begin
          status_d = ST_ALREADY_FREE;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata & ~free_mask;
          free_cnt_d = free_cnt_q + CNT_W'(1);
          used_cnt_d = used_cnt_q - CNT_W'(1);
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
    // a page_count write restarts the map
    if (cfg_wr) begin
      page_count_d = cfg_val;
      ptr_d        = '0;
      ram_we       = 1'b0;
      if (32'(RESERVED_PAGES) < 32'(cfg_val)) begin
        used_cnt_d = CNT_W'(RESERVED_PAGES);
        free_cnt_d = cfg_val - CNT_W'(RESERVED_PAGES);
      end else begin
        used_cnt_d = cfg_val;
        free_cnt_d = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      page_count_q <= CNT_W'(MAX_PAGES);
      free_cnt_q   <= CNT_W'(MAX_PAGES - RST_RSV);
      used_cnt_q   <= CNT_W'(RST_RSV);
      ptr_q        <= '0;
    end else begin
      state_q      <= state_d;
      page_count_q <= page_count_d;
      free_cnt_q   <= free_cnt_d;
      used_cnt_q   <= used_cnt_d;
      ptr_q        <= ptr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      addr_q <= free_address_i;
    end
    status_q <= status_d;
    pa_q     <= pa_d;
  end

  // used-bit map; writes land before the next command can read
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // outputs
  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign status_o       = status_q;
  assign page_address_o = pa_q;
  assign free_count_o   = free_cnt_q;
  assign used_count_o   = used_cnt_q;

  // counters add up to the page count whenever the sequencer is idle
  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ((CNT_W+1)'(free_cnt_q) + (CNT_W+1)'(used_cnt_q)) == (CNT_W+1)'(page_count_q))
    else $error("free and used counters disagree with page count");

  // a query answers on the following cycle
  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i != OP_ALLOC && operation_i != OP_FREE && !cfg_wr) |=> done_o)
    else $error("query did not answer on the next cycle");

  // result strobe lasts one cycle
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // only a successful alloc carries a page address
  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (op_q != OP_ALLOC || status_o != ST_OK)) |-> (page_address_o == '0))
    else $error("page address set outside a successful alloc");

endmodule
